FILE: hw/rtl/assert_macros.svh
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every sampled edge
`define MBCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition on one edge implies a condition on the next edge
`define MBCE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hw/rtl/mbce_pkg.sv
`timescale 1ns / 1ps

package mbce_pkg;

    localparam int LANES      = 8;
    localparam int PIX_W      = 32;
    localparam int DIM_W      = 11;
    localparam int CNT_W      = 4;
    localparam int SRC_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PIXELS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS  = 3'd5;

    typedef struct packed {
        logic [SRC_W-1:0] source_byte;
        logic [PIX_W-1:0] old_pixel_0;
        logic [PIX_W-1:0] old_pixel_1;
        logic [PIX_W-1:0] old_pixel_2;
        logic [PIX_W-1:0] old_pixel_3;
        logic [PIX_W-1:0] old_pixel_4;
        logic [PIX_W-1:0] old_pixel_5;
        logic [PIX_W-1:0] old_pixel_6;
        logic [PIX_W-1:0] old_pixel_7;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] new_pixel_0;
        logic [PIX_W-1:0] new_pixel_1;
        logic [PIX_W-1:0] new_pixel_2;
        logic [PIX_W-1:0] new_pixel_3;
        logic [PIX_W-1:0] new_pixel_4;
        logic [PIX_W-1:0] new_pixel_5;
        logic [PIX_W-1:0] new_pixel_6;
        logic [PIX_W-1:0] new_pixel_7;
        logic [CNT_W-1:0] pixel_count;
        logic             row_end;
        logic             blit_end;
    } out_item_t;

    // effective settings, colors already masked and dimensions clamped
    typedef struct packed {
        logic             xor_mode;
        logic [PIX_W-1:0] mask;
        logic [PIX_W-1:0] bg;
        logic [PIX_W-1:0] fg;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    // classified beat handed from front to back
    typedef struct packed {
        logic [SRC_W-1:0]            source_byte;
        logic [LANES-1:0][PIX_W-1:0] old_pixel;
        logic [CNT_W-1:0]            pixel_count;
        logic                        row_end;
        logic                        blit_end;
    } job_t;

endpackage

FILE: hw/rtl/mbce_cfg.sv
`timescale 1ns / 1ps

module mbce_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_en,
    input  logic [mbce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbce_pkg::CFG_DATA_W-1:0]     cfg_data,
    output mbce_pkg::cfg_t                      cfg
);

    localparam int DIM_MAX = (1 << mbce_pkg::DIM_W) - 1;
    localparam int W_LIM   = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int H_LIM   = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam logic [mbce_pkg::DIM_W-1:0] W_CAP = mbce_pkg::DIM_W'(W_LIM);
    localparam logic [mbce_pkg::DIM_W-1:0] H_CAP = mbce_pkg::DIM_W'(H_LIM);
    localparam logic [mbce_pkg::DIM_W-1:0] DIM_ONE = mbce_pkg::DIM_W'(1);

    logic [2:0]                   pixel_bytes_reg;
    logic [mbce_pkg::PIX_W-1:0]   bg_color_reg;
    logic [mbce_pkg::PIX_W-1:0]   fg_color_reg;
    logic                         xor_mode_reg;
    logic [mbce_pkg::DIM_W-1:0]   width_pixels_reg;
    logic [mbce_pkg::DIM_W-1:0]   height_rows_reg;
    logic [mbce_pkg::PIX_W-1:0]   mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_bytes_reg  <= 3'd1;
            bg_color_reg     <= '0;
            fg_color_reg     <= mbce_pkg::PIX_W'(1);
            xor_mode_reg     <= 1'b0;
            width_pixels_reg <= DIM_ONE;
            height_rows_reg  <= DIM_ONE;
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                mbce_pkg::CFG_PIXEL_BYTES:  pixel_bytes_reg  <= cfg_data[2:0];
                mbce_pkg::CFG_BG_COLOR:     bg_color_reg     <= cfg_data;
                mbce_pkg::CFG_FG_COLOR:     fg_color_reg     <= cfg_data;
                mbce_pkg::CFG_XOR_MODE:     xor_mode_reg     <= cfg_data[0];
                mbce_pkg::CFG_WIDTH_PIXELS: width_pixels_reg <= cfg_data[mbce_pkg::DIM_W-1:0];
                mbce_pkg::CFG_HEIGHT_ROWS:  height_rows_reg  <= cfg_data[mbce_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (pixel_bytes_reg) inside
            3'd0, 3'd1: mask = 32'h0000_00FF;
            3'd2:       mask = 32'h0000_FFFF;
            3'd3:       mask = 32'h00FF_FFFF;
            default:    mask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb
    begin
        cfg.xor_mode = xor_mode_reg;
        cfg.mask     = mask;
        cfg.bg       = bg_color_reg & mask;
        cfg.fg       = fg_color_reg & mask;

        if (width_pixels_reg == '0)
            cfg.width = DIM_ONE;
        else if (width_pixels_reg > W_CAP)
            cfg.width = W_CAP;
        else
            cfg.width = width_pixels_reg;

        if (height_rows_reg == '0)
            cfg.height = DIM_ONE;
        else if (height_rows_reg > H_CAP)
            cfg.height = H_CAP;
        else
            cfg.height = height_rows_reg;
    end

endmodule

FILE: hw/rtl/mbce_front.sv
`timescale 1ns / 1ps

module mbce_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbce_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mbce_pkg::in_item_t   in_data,
    output logic                 q_valid,
    input  logic                 q_ready,
    output mbce_pkg::job_t       q_data
);

    localparam int DW = mbce_pkg::DIM_W;
    localparam int CW = mbce_pkg::CNT_W;
    localparam logic [DW-1:0] LANES_DIM = DW'(mbce_pkg::LANES);
    localparam logic [CW-1:0] LANES_CNT = CW'(mbce_pkg::LANES);

    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] row_reg, row_next;
    logic [DW-1:0] col, row, remain;
    logic [CW-1:0] count;
    logic [DW:0]   col_sum, row_inc;
    logic          row_end, blit_end;
    logic          take;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign take     = in_valid && q_ready;

    always_comb
    begin
        col      = (col_reg >= cfg.width) ? '0 : col_reg;
        row      = (row_reg >= cfg.height) ? '0 : row_reg;
        remain   = cfg.width - col;
        count    = (remain > LANES_DIM) ? LANES_CNT : remain[CW-1:0];
        col_sum  = {1'b0, col} + {{(DW+1-CW){1'b0}}, count};
        row_inc  = {1'b0, row} + {{DW{1'b0}}, 1'b1};
        row_end  = (col_sum >= {1'b0, cfg.width});
        blit_end = row_end && (row_inc >= {1'b0, cfg.height});
        col_next = row_end ? '0 : col_sum[DW-1:0];
        if (!row_end)
            row_next = row;
        else if (blit_end)
            row_next = '0;
        else
            row_next = row_inc[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        q_data.source_byte  = in_data.source_byte;
        q_data.old_pixel[0] = in_data.old_pixel_0;
        q_data.old_pixel[1] = in_data.old_pixel_1;
        q_data.old_pixel[2] = in_data.old_pixel_2;
        q_data.old_pixel[3] = in_data.old_pixel_3;
        q_data.old_pixel[4] = in_data.old_pixel_4;
        q_data.old_pixel[5] = in_data.old_pixel_5;
        q_data.old_pixel[6] = in_data.old_pixel_6;
        q_data.old_pixel[7] = in_data.old_pixel_7;
        q_data.pixel_count  = count;
        q_data.row_end      = row_end;
        q_data.blit_end     = blit_end;
    end

endmodule

FILE: hw/rtl/mbce_queue.sv
`timescale 1ns / 1ps

module mbce_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  mbce_pkg::job_t   push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mbce_pkg::job_t   pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    mbce_pkg::job_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               push, pop;

    assign push_ready = (cnt_reg != FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: hw/rtl/mbce_back.sv
`timescale 1ns / 1ps

module mbce_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbce_pkg::cfg_t       cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  mbce_pkg::job_t       pop_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mbce_pkg::out_item_t  out_data
);

    localparam int N  = mbce_pkg::LANES;
    localparam int PW = mbce_pkg::PIX_W;
    localparam int CW = mbce_pkg::CNT_W;

    logic                   out_valid_reg;
    mbce_pkg::out_item_t    out_data_reg, out_data_next;
    logic [N-1:0][PW-1:0]   res;
    logic [PW-1:0]          old;
    logic                   src_bit;
    logic                   load;

    assign pop_ready = !out_valid_reg || out_ready;
    assign load      = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        res = '0;
        for (int i = 0; i < N; i++)
        begin
            old     = pop_data.old_pixel[i] & cfg.mask;
            src_bit = pop_data.source_byte[N-1-i];
            if (CW'(i) < pop_data.pixel_count)
            begin
                if (cfg.xor_mode)
                    res[i] = src_bit ? ((old == cfg.bg) ? cfg.fg : cfg.bg) : old;
                else
                    res[i] = src_bit ? cfg.fg : cfg.bg;
            end
        end
    end

    always_comb
    begin
        out_data_next.new_pixel_0 = res[0];
        out_data_next.new_pixel_1 = res[1];
        out_data_next.new_pixel_2 = res[2];
        out_data_next.new_pixel_3 = res[3];
        out_data_next.new_pixel_4 = res[4];
        out_data_next.new_pixel_5 = res[5];
        out_data_next.new_pixel_6 = res[6];
        out_data_next.new_pixel_7 = res[7];
        out_data_next.pixel_count = pop_data.pixel_count;
        out_data_next.row_end     = pop_data.row_end;
        out_data_next.blit_end    = pop_data.blit_end;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

endmodule

FILE: hw/rtl/mono_bitmap_color_expand_blit_top.sv
`timescale 1ns / 1ps

// channel   handshake             payload
// ------    ---------             -------
// in        in_valid / in_ready   in_data   (source byte + 8 old pixels)
// out       out_valid / out_ready out_data  (8 new pixels, count, row/blit end)
// cfg       cfg_en                cfg_index, cfg_data
//
// one beat per cycle sustained while out_ready is high
// front updates column/row counters on accept, back expands 8 lanes, XOR compares
// a two-entry queue sits between them, the output register holds a stalled beat
// rst_n clears counters, queue, output valid and loads register defaults

module mono_bitmap_color_expand_blit_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_en,
    input  logic [mbce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mbce_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output mbce_pkg::out_item_t              out_data
);

    mbce_pkg::cfg_t  cfg;
    mbce_pkg::job_t  push_data, pop_data;
    logic            push_valid, push_ready;
    logic            pop_valid, pop_ready;

    mbce_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (push_valid),
        .q_ready  (push_ready),
        .q_data   (push_data)
    );

    mbce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mbce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: hw/rtl/mbce_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbce_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  mbce_pkg::out_item_t  out_data
);

    `MBCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat dropped or changed while stalled")
    `MBCE_ASSERT(a_count_range, !out_valid || (out_data.pixel_count != 4'd0 && out_data.pixel_count <= 4'd8), "pixel count out of range")
    `MBCE_ASSERT(a_blit_row, !out_valid || !out_data.blit_end || out_data.row_end, "blit end without row end")
    `MBCE_ASSERT(a_mid_row_full, !out_valid || out_data.row_end || out_data.pixel_count == 4'd8, "short beat in the middle of a row")
    `MBCE_ASSERT(a_tail_zero, !out_valid || out_data.pixel_count == 4'd8 || out_data.new_pixel_7 == '0, "unused lane not zero")

endmodule

bind mono_bitmap_color_expand_blit_top mbce_checker u_mbce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: bench/mono_bitmap_color_expand_blit_top_tb.sv
`timescale 1ns / 1ps

module mono_bitmap_color_expand_blit_top_tb;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int RANDOM_ITEMS = 650;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;

    class pixel_expand_scoreboard;
        logic [2:0]          pixel_bytes;
        logic [31:0]         bg_color;
        logic [31:0]         fg_color;
        logic                xor_mode;
        logic [10:0]         width_pixels;
        logic [10:0]         height_rows;
        int                  column_pos;
        int                  row_pos;
        mbce_pkg::out_item_t expected_beats[$];
        int                  errors;

        function new();
            pixel_bytes  = 3'd1;
            bg_color     = 32'h0;
            fg_color     = 32'h1;
            xor_mode     = 1'b0;
            width_pixels = 11'd1;
            height_rows  = 11'd1;
            column_pos   = 0;
            row_pos      = 0;
            errors       = 0;
        endfunction

        function void write_register(logic [mbce_pkg::CFG_IDX_W-1:0] idx,
                                     logic [31:0] value);
            case (idx)
                mbce_pkg::CFG_PIXEL_BYTES:  pixel_bytes  = value[2:0];
                mbce_pkg::CFG_BG_COLOR:     bg_color     = value;
                mbce_pkg::CFG_FG_COLOR:     fg_color     = value;
                mbce_pkg::CFG_XOR_MODE:     xor_mode     = value[0];
                mbce_pkg::CFG_WIDTH_PIXELS: width_pixels = value[10:0];
                mbce_pkg::CFG_HEIGHT_ROWS:  height_rows  = value[10:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] color_mask();
            case (pixel_bytes)
                3'd0, 3'd1: return 32'h0000_00FF;
                3'd2:       return 32'h0000_FFFF;
                3'd3:       return 32'h00FF_FFFF;
                default:    return 32'hFFFF_FFFF;
            endcase
        endfunction

        function int clamp_dim(int v, int maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        function void note_source_beat(mbce_pkg::in_item_t item);
            logic [31:0] mask;
            logic [31:0] bg;
            logic [31:0] fg;
            logic [31:0] olds [8];
            logic [31:0] res [8];
            logic [31:0] old;
            int          w;
            int          h;
            int          col;
            int          row;
            int          count;
            logic        row_done;
            logic        blit_done;
            mask = color_mask();
            bg   = bg_color & mask;
            fg   = fg_color & mask;
            w    = clamp_dim(width_pixels, MAX_WIDTH);
            h    = clamp_dim(height_rows, MAX_HEIGHT);
            col  = column_pos;
            row  = row_pos;
            olds = '{item.old_pixel_0, item.old_pixel_1, item.old_pixel_2, item.old_pixel_3,
                     item.old_pixel_4, item.old_pixel_5, item.old_pixel_6, item.old_pixel_7};
            if (col >= w)
                col = 0;
            if (row >= h)
                row = 0;
            count = (w - col > 8) ? 8 : w - col;
            for (int i = 0; i < 8; i++)
            begin
                res[i] = 32'h0;
                if (i < count)
                begin
                    old = olds[i] & mask;
                    if (xor_mode)
                        res[i] = item.source_byte[7 - i] ? ((old == bg) ? fg : bg) : old;
                    else
                        res[i] = item.source_byte[7 - i] ? fg : bg;
                end
            end
            row_done  = 1'b0;
            blit_done = 1'b0;
            col += count;
            if (col >= w)
            begin
                col      = 0;
                row_done = 1'b1;
                row++;
                if (row >= h)
                begin
                    row       = 0;
                    blit_done = 1'b1;
                end
            end
            column_pos = col;
            row_pos    = row;
            expected_beats.push_back('{res[0], res[1], res[2], res[3], res[4], res[5], res[6],
                                       res[7], count[3:0], row_done, blit_done});
        endfunction

        function void check_pixel_beat(mbce_pkg::out_item_t got);
            mbce_pkg::out_item_t want;
            logic [31:0]         want_px [8];
            logic [31:0]         got_px [8];
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected output beat, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want    = expected_beats.pop_front();
            want_px = '{want.new_pixel_0, want.new_pixel_1, want.new_pixel_2, want.new_pixel_3,
                        want.new_pixel_4, want.new_pixel_5, want.new_pixel_6, want.new_pixel_7};
            got_px  = '{got.new_pixel_0, got.new_pixel_1, got.new_pixel_2, got.new_pixel_3,
                        got.new_pixel_4, got.new_pixel_5, got.new_pixel_6, got.new_pixel_7};
            for (int i = 0; i < 8; i++)
            begin
                if (got_px[i] !== want_px[i])
                begin
                    $display("%0t: new_pixel_%0d expected %h actual %h",
                             $time, i, want_px[i], got_px[i]);
                    errors++;
                end
            end
            if (got.pixel_count !== want.pixel_count)
            begin
                $display("%0t: pixel_count expected %0d actual %0d",
                         $time, want.pixel_count, got.pixel_count);
                errors++;
            end
            if (got.row_end !== want.row_end)
            begin
                $display("%0t: row_end expected %b actual %b", $time, want.row_end, got.row_end);
                errors++;
            end
            if (got.blit_end !== want.blit_end)
            begin
                $display("%0t: blit_end expected %b actual %b",
                         $time, want.blit_end, got.blit_end);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_en;
    logic [mbce_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mbce_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    mbce_pkg::in_item_t              in_data;
    logic                            out_valid;
    logic                            out_ready;
    mbce_pkg::out_item_t             out_data;

    pixel_expand_scoreboard sb;
    bit                     rx_stalls;
    int                     stall_left;
    int                     cycle_count;

    mono_bitmap_color_expand_blit_top #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_en)
                sb.write_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_source_beat(in_data);
            if (out_valid && out_ready)
                sb.check_pixel_beat(out_data);
        end
    end

    function automatic int pick_gap(bit enable);
        int r;
        if (!enable)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sink side backpressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_stalls && $urandom_range(0, 3) == 0)
                stall_left = pick_gap(1'b1);
        end
    end

    function automatic logic [31:0] pick_old_pixel();
        logic [31:0] mask;
        mask = sb.color_mask();
        case ($urandom_range(0, 4))
            0:       return (sb.bg_color & mask) | ($urandom & ~mask);
            1:       return (sb.fg_color & mask) | ($urandom & ~mask);
            2:       return sb.bg_color & mask;
            default: return $urandom;
        endcase
    endfunction

    function automatic mbce_pkg::in_item_t make_item(logic [7:0] src);
        return '{src, pick_old_pixel(), pick_old_pixel(), pick_old_pixel(), pick_old_pixel(),
                 pick_old_pixel(), pick_old_pixel(), pick_old_pixel(), pick_old_pixel()};
    endfunction

    task automatic send_item(input mbce_pkg::in_item_t item, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [mbce_pkg::CFG_IDX_W-1:0] idx,
                              input logic [31:0] value);
        @(negedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic cfg_release();
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic randomize_config(input bit wide);
        logic [31:0] color;
        int          r;
        int          dim;
        if ($urandom_range(0, 1))
            set_config(mbce_pkg::CFG_PIXEL_BYTES, ($urandom & ~32'h7) | $urandom_range(0, 7));
        if ($urandom_range(0, 1))
        begin
            r     = $urandom_range(0, 7);
            color = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            set_config(mbce_pkg::CFG_BG_COLOR, color);
        end
        if ($urandom_range(0, 1))
        begin
            r     = $urandom_range(0, 7);
            color = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? sb.bg_color
                  : $urandom;
            set_config(mbce_pkg::CFG_FG_COLOR, color);
        end
        if ($urandom_range(0, 1))
            set_config(mbce_pkg::CFG_XOR_MODE, $urandom);
        if (wide || $urandom_range(0, 1))
        begin
            r = $urandom_range(0, 99);
            if (wide)
                dim = 2047;
            else if (r < 3)
                dim = 0;
            else if (r < 9)
            begin
                case ($urandom_range(0, 3))
                    0:       dim = 1024;
                    1:       dim = 1025;
                    2:       dim = 2047;
                    default: dim = $urandom_range(65, 1023);
                endcase
            end
            else
                dim = $urandom_range(1, 40);
            set_config(mbce_pkg::CFG_WIDTH_PIXELS, ($urandom & ~32'h7FF) | dim);
        end
        if (wide || $urandom_range(0, 1))
        begin
            r = $urandom_range(0, 99);
            if (wide)
                dim = 1;
            else if (r < 5)
                dim = 0;
            else if (r < 10)
                dim = 2047;
            else
                dim = $urandom_range(1, 4);
            set_config(mbce_pkg::CFG_HEIGHT_ROWS, ($urandom & ~32'h7FF) | dim);
        end
        cfg_release();
    endtask

    initial
    begin
        logic [7:0] srcs [$];
        int         random_sent;
        int         phase;
        int         n;
        bit         tx_gaps;
        sb          = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_en      = 1'b0;
        cfg_index   = mbce_pkg::CFG_PIXEL_BYTES;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        rx_stalls   = 1'b0;
        stall_left  = 0;
        cycle_count = 0;
        random_sent = 0;
        phase       = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default settings, one pixel per blit
        send_item(make_item(8'h80), 0);
        send_item(make_item(8'h7F), 0);
        wait_idle();

        set_config(mbce_pkg::CFG_PIXEL_BYTES, 32'd4);
        set_config(mbce_pkg::CFG_BG_COLOR, 32'hFFFF_FFFF);
        set_config(mbce_pkg::CFG_FG_COLOR, 32'h0);
        set_config(mbce_pkg::CFG_WIDTH_PIXELS, 32'd13);
        set_config(mbce_pkg::CFG_HEIGHT_ROWS, 32'd2);
        cfg_release();
        srcs = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
        foreach (srcs[i])
            send_item(make_item(srcs[i]), 0);
        wait_idle();

        set_config(mbce_pkg::CFG_PIXEL_BYTES, 32'd1);
        set_config(mbce_pkg::CFG_BG_COLOR, 32'h1234_5678);
        set_config(mbce_pkg::CFG_FG_COLOR, 32'hABCD_EF01);
        set_config(mbce_pkg::CFG_XOR_MODE, 32'd1);
        set_config(mbce_pkg::CFG_WIDTH_PIXELS, 32'd16);
        set_config(mbce_pkg::CFG_HEIGHT_ROWS, 32'd1);
        cfg_release();
        send_item(make_item(8'hFF), 0);
        send_item(make_item(8'h0F), 1);
        wait_idle();

        // odd pixel sizes
        set_config(mbce_pkg::CFG_PIXEL_BYTES, 32'd0);
        set_config(mbce_pkg::CFG_WIDTH_PIXELS, 32'd8);
        cfg_release();
        send_item(make_item(8'hC3), 0);
        wait_idle();
        set_config(mbce_pkg::CFG_PIXEL_BYTES, 32'd7);
        cfg_release();
        send_item(make_item(8'h3C), 0);
        wait_idle();
        set_config(mbce_pkg::CFG_PIXEL_BYTES, 32'd2);
        cfg_release();
        send_item(make_item(8'h96), 0);
        wait_idle();
        set_config(mbce_pkg::CFG_PIXEL_BYTES, 32'd3);
        cfg_release();
        send_item(make_item(8'h69), 0);
        wait_idle();

        // zero and oversized dimensions
        set_config(mbce_pkg::CFG_WIDTH_PIXELS, 32'd0);
        set_config(mbce_pkg::CFG_HEIGHT_ROWS, 32'd0);
        set_config(mbce_pkg::CFG_XOR_MODE, 32'd0);
        cfg_release();
        send_item(make_item(8'h55), 0);
        wait_idle();
        set_config(mbce_pkg::CFG_WIDTH_PIXELS, 32'd2047);
        set_config(mbce_pkg::CFG_HEIGHT_ROWS, 32'd2047);
        cfg_release();
        send_item(make_item(8'hAA), 0);
        send_item(make_item(8'hFE), 0);
        wait_idle();

        // shrink mid-blit so the counters fall outside the rectangle
        set_config(mbce_pkg::CFG_WIDTH_PIXELS, 32'd10);
        cfg_release();
        send_item(make_item(8'h01), 0);
        send_item(make_item(8'h7E), 0);
        wait_idle();
        set_config(mbce_pkg::CFG_WIDTH_PIXELS, 32'd1);
        set_config(mbce_pkg::CFG_HEIGHT_ROWS, 32'd2);
        cfg_release();
        send_item(make_item(8'h81), 0);
        send_item(make_item(8'h18), 0);
        wait_idle();

        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            randomize_config(phase == 2);
            rx_stalls = ($urandom_range(0, 3) != 0);
            tx_gaps   = ($urandom_range(0, 3) != 0);
            if (sb.width_pixels > 64)
                n = $urandom_range(129, 140);
            else
                n = $urandom_range(1, 40);
            if (n > RANDOM_ITEMS - random_sent)
                n = RANDOM_ITEMS - random_sent;
            repeat (n)
            begin
                send_item(make_item($urandom_range(0, 255)), pick_gap(tx_gaps));
                random_sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mbce_pkg.sv
hw/rtl/mbce_cfg.sv
hw/rtl/mbce_front.sv
hw/rtl/mbce_queue.sv
hw/rtl/mbce_back.sv
hw/rtl/mono_bitmap_color_expand_blit_top.sv
hw/rtl/mbce_checker.sv
bench/mono_bitmap_color_expand_blit_top_tb.sv
